// ----- sv/rfth_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfth_pkg
// Field widths and request codes shared by the time histogrammer modules.
// ----------------------------------------------------------------------------
package rfth_pkg;

    localparam int FUNC_W     = 2;
    localparam int POS_W      = 5;
    localparam int CORE_W     = 2;
    localparam int TIME_W     = 24;
    localparam int PHASE_W    = 20;
    localparam int BIN_W      = 15;
    localparam int COUNT_W    = 32;
    localparam int PBIN_OUT_W = 12;

    localparam logic [FUNC_W-1:0] FUNC_HIT        = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ_TIME  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ_PHASE = 2'd2;

    // offsets of the flag bins below the top of each histogram
    localparam int PHASE_FORCED_OFS = 100;
    localparam int TIME_UNDER_OFS   = 200;
    localparam int TIME_OVER_OFS    = 300;
    localparam int TIME_NORF_OFS    = 400;

endpackage
`default_nettype wire

// ----- sv/rfth_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfth_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rfth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/rfth_bin_calc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfth_bin_calc
// Two stage bin computation: raw time and rounded RF phase bin, then the
// RF corrected time with clamping to the flag bins.
// ----------------------------------------------------------------------------
module rfth_bin_calc #(
    parameter int TIME_BINS   = 32768,
    parameter int PHASE_BINS  = 4096,
    parameter int TIME_OFFSET = 16384
) (
    input  wire logic                               aclk,
    input  wire logic [rfth_pkg::TIME_W-1:0]        cfd_time,
    input  wire logic [rfth_pkg::TIME_W-1:0]        timestamp_low,
    input  wire logic                               rf_present,
    input  wire logic signed [rfth_pkg::PHASE_W-1:0] rf_phase,
    output logic      [$clog2(TIME_BINS)-1:0]       tbin,
    output logic      [$clog2(PHASE_BINS)-1:0]      pbin,
    output logic                                    rf_used
);
    import rfth_pkg::*;

    localparam int TW = $clog2(TIME_BINS);
    localparam int PW = $clog2(PHASE_BINS);

    logic signed [TIME_W+1:0] t1_reg;
    logic [PW-1:0]            p1_reg;
    logic                     rf1_reg;

    logic [15:0]              q;
    logic [3:0]               frac;
    logic [PW-1:0]            p1_next;
    logic signed [TIME_W+1:0] t1_next;

    always_comb begin
        frac = rf_phase[3:0];
        q    = {1'b0, rf_phase[PHASE_W-2:4]};
        if (frac > 4'd8 || (frac == 4'd8 && q[0])) begin
            q = q + 16'd1;
        end
        if (rf_phase[PHASE_W-1] || q >= 16'(PHASE_BINS)) begin
            p1_next = PW'(PHASE_BINS - PHASE_FORCED_OFS);
        end else begin
            p1_next = PW'(q);
        end
        // timestamp is scaled by 16 and kept to 24 bits
        t1_next = $signed({2'b00, cfd_time}) -
                  $signed({2'b00, timestamp_low[TIME_W-5:0], 4'b0000});
    end

    always_ff @(posedge aclk) begin
        t1_reg  <= t1_next;
        p1_reg  <= p1_next;
        rf1_reg <= rf_present;
    end

    logic signed [TIME_W+2:0] t2;
    logic [TW-1:0]            tbin_next;

    always_comb begin
        t2 = (TIME_W+3)'(t1_reg) - (TIME_W+3)'(p1_reg) + (TIME_W+3)'(TIME_OFFSET);
        if (!rf1_reg) begin
            tbin_next = TW'(TIME_BINS - TIME_NORF_OFS);
        end else if (t2[TIME_W+2]) begin
            tbin_next = TW'(TIME_BINS - TIME_UNDER_OFS);
        end else if (t2[TIME_W+1:0] >= (TIME_W+2)'(TIME_BINS)) begin
            tbin_next = TW'(TIME_BINS - TIME_OVER_OFS);
        end else begin
            tbin_next = TW'(t2);
        end
    end

    always_ff @(posedge aclk) begin
        tbin    <= tbin_next;
        pbin    <= rf1_reg ? p1_reg : '0;
        rf_used <= rf1_reg;
    end

endmodule
`default_nettype wire

// ----- sv/rf_corrected_time_histogrammer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rf_corrected_time_histogrammer
// Per position and core histograms of RF corrected hit times and RF phases.
// Flow: a request passes the bin calc states, RAM read and write back, which stalls
// while a result is held; the next request is only taken after that write back.
// Reset: a clearing pass writes zero to every counter, one entry per cycle, while
// s_ready stays low.
// ----------------------------------------------------------------------------
module rf_corrected_time_histogrammer #(
    parameter int NUM_POSITIONS = 16,
    parameter int NUM_CORES     = 4,
    parameter int TIME_BINS     = 32768,
    parameter int PHASE_BINS    = 4096,
    parameter int TIME_OFFSET   = 16384
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [rfth_pkg::FUNC_W-1:0]         s_func,
    input  wire logic [rfth_pkg::POS_W-1:0]          s_position,
    input  wire logic [rfth_pkg::CORE_W-1:0]         s_core,
    input  wire logic [rfth_pkg::TIME_W-1:0]         s_cfd_time,
    input  wire logic [rfth_pkg::TIME_W-1:0]         s_timestamp_low,
    input  wire logic                                s_rf_present,
    input  wire logic signed [rfth_pkg::PHASE_W-1:0] s_rf_phase,
    input  wire logic [rfth_pkg::BIN_W-1:0]          s_read_bin,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [rfth_pkg::COUNT_W-1:0]             m_count,
    output logic [rfth_pkg::BIN_W-1:0]               m_time_bin,
    output logic [rfth_pkg::PBIN_OUT_W-1:0]          m_phase_bin,
    output logic                                     m_rf_used
);
    import rfth_pkg::*;

    localparam int SLOTS   = NUM_POSITIONS * NUM_CORES;
    localparam int T_DEPTH = SLOTS * TIME_BINS;
    localparam int P_DEPTH = SLOTS * PHASE_BINS;
    localparam int C_DEPTH = (T_DEPTH > P_DEPTH) ? T_DEPTH : P_DEPTH;
    localparam int TAW     = $clog2(T_DEPTH);
    localparam int PAW     = $clog2(P_DEPTH);
    localparam int CW      = $clog2(C_DEPTH);
    localparam int TW      = $clog2(TIME_BINS);
    localparam int PW      = $clog2(PHASE_BINS);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_CALC1, ST_CALC2, ST_RD, ST_WR
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] clr_cnt_reg, clr_cnt_next;

    // request
    logic [FUNC_W-1:0]         func_reg, func_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [CORE_W-1:0]         core_reg, core_next;
    logic [TIME_W-1:0]         cfd_reg, cfd_next;
    logic [TIME_W-1:0]         ts_reg, ts_next;
    logic                      rfp_reg, rfp_next;
    logic signed [PHASE_W-1:0] phase_reg, phase_next;
    logic [BIN_W-1:0]          rbin_reg, rbin_next;

    logic           ok_reg, ok_next;
    logic [TAW-1:0] tbase_reg, tbase_next;
    logic [PAW-1:0] pbase_reg, pbase_next;
    logic [TAW-1:0] taddr_reg, taddr_next;
    logic [PAW-1:0] paddr_reg, paddr_next;
    logic           inrange_reg, inrange_next;

    logic                  m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0]    m_count_reg, m_count_next;
    logic [BIN_W-1:0]      m_time_bin_reg, m_time_bin_next;
    logic [PBIN_OUT_W-1:0] m_phase_bin_reg, m_phase_bin_next;
    logic                  m_rf_used_reg, m_rf_used_next;

    logic [TW-1:0] tbin;
    logic [PW-1:0] pbin;
    logic          rf_used;

    logic               t_we, p_we, t_re, p_re;
    logic [TAW-1:0]     t_waddr;
    logic [PAW-1:0]     p_waddr;
    logic [COUNT_W-1:0] t_wdata, p_wdata, t_rdata, p_rdata;
    logic [COUNT_W-1:0] t_inc, p_inc;
    logic               is_hit, fire;

    rfth_bin_calc #(
        .TIME_BINS  (TIME_BINS),
        .PHASE_BINS (PHASE_BINS),
        .TIME_OFFSET(TIME_OFFSET)
    ) u_bin_calc (
        .aclk         (aclk),
        .cfd_time     (cfd_reg),
        .timestamp_low(ts_reg),
        .rf_present   (rfp_reg),
        .rf_phase     (phase_reg),
        .tbin         (tbin),
        .pbin         (pbin),
        .rf_used      (rf_used)
    );

    rfth_ram #(.WIDTH(COUNT_W), .DEPTH(T_DEPTH)) u_time_ram (
        .aclk (aclk),
        .we   (t_we),
        .waddr(t_waddr),
        .wdata(t_wdata),
        .re   (t_re),
        .raddr(taddr_next),
        .rdata(t_rdata)
    );

    rfth_ram #(.WIDTH(COUNT_W), .DEPTH(P_DEPTH)) u_phase_ram (
        .aclk (aclk),
        .we   (p_we),
        .waddr(p_waddr),
        .wdata(p_wdata),
        .re   (p_re),
        .raddr(paddr_next),
        .rdata(p_rdata)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_count     = m_count_reg;
    assign m_time_bin  = m_time_bin_reg;
    assign m_phase_bin = m_phase_bin_reg;
    assign m_rf_used   = m_rf_used_reg;

    assign is_hit = (func_reg == FUNC_HIT);
    assign fire   = (state_reg == ST_WR) && (!m_valid_reg || m_ready);
    // saturating increments
    assign t_inc  = (t_rdata == COUNT_MAX) ? t_rdata : t_rdata + 1'b1;
    assign p_inc  = (p_rdata == COUNT_MAX) ? p_rdata : p_rdata + 1'b1;

    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        func_next        = func_reg;
        pos_next         = pos_reg;
        core_next        = core_reg;
        cfd_next         = cfd_reg;
        ts_next          = ts_reg;
        rfp_next         = rfp_reg;
        phase_next       = phase_reg;
        rbin_next        = rbin_reg;
        ok_next          = ok_reg;
        tbase_next       = tbase_reg;
        pbase_next       = pbase_reg;
        taddr_next       = taddr_reg;
        paddr_next       = paddr_reg;
        inrange_next     = inrange_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_count_next     = m_count_reg;
        m_time_bin_next  = m_time_bin_reg;
        m_phase_bin_next = m_phase_bin_reg;
        m_rf_used_next   = m_rf_used_reg;
        t_re    = 1'b0;
        p_re    = 1'b0;
        t_we    = 1'b0;
        p_we    = 1'b0;
        t_waddr = taddr_reg;
        p_waddr = paddr_reg;
        t_wdata = t_inc;
        p_wdata = p_inc;

        case (state_reg)
            ST_CLEAR: begin
                t_we    = (32'(clr_cnt_reg) < 32'(T_DEPTH));
                p_we    = (32'(clr_cnt_reg) < 32'(P_DEPTH));
                t_waddr = TAW'(clr_cnt_reg);
                p_waddr = PAW'(clr_cnt_reg);
                t_wdata = '0;
                p_wdata = '0;
                if (32'(clr_cnt_reg) == 32'(C_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    func_next  = s_func;
                    pos_next   = s_position;
                    core_next  = s_core;
                    cfd_next   = s_cfd_time;
                    ts_next    = s_timestamp_low;
                    rfp_next   = s_rf_present;
                    phase_next = s_rf_phase;
                    rbin_next  = s_read_bin;
                    state_next = ST_CALC1;
                end
            end
            ST_CALC1: begin
                ok_next = (pos_reg != '0) &&
                          (32'(pos_reg) <= 32'(NUM_POSITIONS)) &&
                          (32'(core_reg) < 32'(NUM_CORES));
                tbase_next = TAW'((32'(pos_reg) - 32'd1) * 32'(NUM_CORES * TIME_BINS) +
                                  32'(core_reg) * 32'(TIME_BINS));
                pbase_next = PAW'((32'(pos_reg) - 32'd1) * 32'(NUM_CORES * PHASE_BINS) +
                                  32'(core_reg) * 32'(PHASE_BINS));
                state_next = ST_CALC2;
            end
            ST_CALC2: begin
                state_next = ST_RD;
            end
            ST_RD: begin
                t_re = 1'b1;
                p_re = 1'b1;
                if (is_hit) begin
                    taddr_next = TAW'(32'(tbase_reg) + 32'(tbin));
                    paddr_next = PAW'(32'(pbase_reg) + 32'(pbin));
                end else begin
                    taddr_next = TAW'(32'(tbase_reg) + 32'(rbin_reg));
                    paddr_next = PAW'(32'(pbase_reg) + 32'(rbin_reg));
                end
                if (func_reg == FUNC_READ_TIME) begin
                    inrange_next = 32'(rbin_reg) < 32'(TIME_BINS);
                end else begin
                    inrange_next = 32'(rbin_reg) < 32'(PHASE_BINS);
                end
                state_next = ST_WR;
            end
            ST_WR: begin
                if (fire) begin
                    t_we = is_hit && ok_reg;
                    p_we = is_hit && ok_reg && rf_used;
                    m_valid_next     = 1'b1;
                    m_count_next     = '0;
                    m_time_bin_next  = '0;
                    m_phase_bin_next = '0;
                    m_rf_used_next   = 1'b0;
                    case (func_reg)
                        FUNC_HIT: begin
                            m_count_next     = ok_reg ? t_inc : '0;
                            m_time_bin_next  = BIN_W'(tbin);
                            m_phase_bin_next = PBIN_OUT_W'(pbin);
                            m_rf_used_next   = rf_used;
                        end
                        FUNC_READ_TIME: begin
                            m_count_next = (ok_reg && inrange_reg) ? t_rdata : '0;
                        end
                        FUNC_READ_PHASE: begin
                            m_count_next = (ok_reg && inrange_reg) ? p_rdata : '0;
                        end
                        default: begin
                            m_count_next = '0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg        <= func_next;
        pos_reg         <= pos_next;
        core_reg        <= core_next;
        cfd_reg         <= cfd_next;
        ts_reg          <= ts_next;
        rfp_reg         <= rfp_next;
        phase_reg       <= phase_next;
        rbin_reg        <= rbin_next;
        ok_reg          <= ok_next;
        tbase_reg       <= tbase_next;
        pbase_reg       <= pbase_next;
        taddr_reg       <= taddr_next;
        paddr_reg       <= paddr_next;
        inrange_reg     <= inrange_next;
        m_count_reg     <= m_count_next;
        m_time_bin_reg  <= m_time_bin_next;
        m_phase_bin_reg <= m_phase_bin_next;
        m_rf_used_reg   <= m_rf_used_next;
    end

    // a new result only comes out of the write back step
    a_result_from_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_WR))
        else $error("result appeared outside write back");

    // counter updates outside the clearing pass never write zero
    a_no_zero_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (t_we && state_reg != ST_CLEAR) |-> (t_wdata != '0))
        else $error("time counter update wrote zero");

    // phase counter only bumps together with its time counter
    a_phase_with_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_we && state_reg != ST_CLEAR) |-> (t_we && rf_used))
        else $error("phase counter written without time counter");

    // a held result is not replaced before it is taken
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_count))
        else $error("pending result overwritten");

endmodule
`default_nettype wire
